// ===== src/esf_pkg.sv =====
// ----------------------------------------------------------------------------
// esf_pkg: shared types for the event subscription fan-out block
// Word layouts on both channels, action and result codes, sequencer states.
// ----------------------------------------------------------------------------
package esf_pkg;

  localparam int EVT_W = 6;
  localparam int OBJ_W = 5;

  typedef enum logic [1:0] {
    ACT_SUBSCRIBE   = 2'd0,
    ACT_UNSUBSCRIBE = 2'd1,
    ACT_PUBLISH     = 2'd2,
    ACT_QUERY       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_DELIVERY = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_ACK      = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN
  } state_t;

  typedef struct packed {
    action_t          action;
    logic [EVT_W-1:0] event_index;
    logic [OBJ_W-1:0] object_index;
    logic             counted_event;
    logic             from_interrupt;
  } in_word_t;

  typedef struct packed {
    kind_t            result_kind;
    logic [OBJ_W-1:0] dest_object;
    logic [EVT_W-1:0] event_out;
    logic             add_reference;
    logic             is_subscribed;
    logic             interrupt_path;
    logic             last;
  } out_word_t;

endpackage

// ===== src/event_subscription_fanout.sv =====
// ----------------------------------------------------------------------------
// event_subscription_fanout: multicast subscription bitmap
// One row of subscriber bits per event. Subscribe, unsubscribe and query each
// answer with one acknowledge word; publish fans out one delivery word per
// subscriber, or a single release word for a counted event with none.
//
// Channels: in_valid/in_ready carry one in_word_t request; out_valid/out_ready
// carry out_word_t results, the final one of each request marked by last.
// An uncounted publish with no subscribers gives no result at all.
// Sequence: a request is accepted in idle, the row is read from the bitmap RAM
// in the next cycle (registered read), and in the exec state an acknowledge or
// release word is loaded into the output register once that register is free.
// A publish with subscribers goes from exec to scan, which loads its deliveries.
// Throughput: one request at a time. A publish sends one delivery word per
// cycle while out_ready stays high, set by the shared lowest-set-bit unit
// working through the row.
// Reset: the sequencer sweeps the RAM writing zero rows, one row per cycle,
// over all min(NUM_EVENTS, 64) rows; in_ready stays low during the sweep.
// Stall: when out_ready is low the held word stays put and the sequencer
// waits; no word is dropped or repeated.
// ----------------------------------------------------------------------------
module event_subscription_fanout
  import esf_pkg::*;
#(
  parameter int NUM_OBJECTS = 32,
  parameter int NUM_EVENTS  = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // object and event fields are 5 and 6 bits, so only that many are reachable
  localparam int ROW_W  = (NUM_OBJECTS > 32) ? 32 : NUM_OBJECTS;
  localparam int ROWS   = (NUM_EVENTS > 64) ? 64 : NUM_EVENTS;
  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  state_t state;
  state_t state_next;

  in_word_t item;                  // latched request
  logic [ROW_W-1:0] rd_row;        // registered RAM read
  logic [ROW_W-1:0] scan;          // bits still to deliver
  logic [ROW_W-1:0] scan_next;
  logic             scan_load;
  logic [ADDR_W-1:0] clr_addr;

  logic [ROW_W-1:0] mem [ROWS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [ROW_W-1:0]  mem_wd;
  logic [ADDR_W-1:0] rd_addr;

  logic evt_ok;
  logic obj_ok;
  logic out_free;
  logic out_load;
  out_word_t out_next;

  logic [ROW_W-1:0] unit_row;
  logic [ROW_W-1:0] upd_row;
  logic             hit;
  logic [OBJ_W-1:0] low_idx;
  logic [ROW_W-1:0] rest;
  logic [ROW_W-1:0] row_eff;

  assign evt_ok   = 32'(item.event_index) < NUM_EVENTS;
  assign obj_ok   = 32'(item.object_index) < NUM_OBJECTS;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign rd_addr  = item.event_index[ADDR_W-1:0];
  assign row_eff  = evt_ok ? rd_row : '0;
  assign unit_row = (state == ST_SCAN) ? scan : row_eff;

  esf_bit_unit #(
    .ROW_W (ROW_W)
  ) u_bit (
    .row     (unit_row),
    .obj     (item.object_index),
    .action  (item.action),
    .upd_row (upd_row),
    .hit     (hit),
    .low_idx (low_idx),
    .rest    (rest)
  );

  // bitmap RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_row <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = rd_addr;
    mem_wd     = upd_row;
    out_load   = 1'b0;
    scan_load  = 1'b0;
    scan_next  = row_eff;
    out_next   = '{result_kind:    KIND_ACK,
                   dest_object:    '0,
                   event_out:      item.event_index,
                   add_reference:  1'b0,
                   is_subscribed:  1'b0,
                   interrupt_path: item.from_interrupt,
                   last:           1'b1};
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
        if (clr_addr == ADDR_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (item.action == ACT_PUBLISH) begin
          if (row_eff != '0) begin
            scan_load  = 1'b1;
            state_next = ST_SCAN;
          end else if (!item.counted_event) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            out_load             = 1'b1;
            out_next.result_kind = KIND_RELEASE;
            state_next           = ST_IDLE;
          end
        end else if (out_free) begin
          // subscribe/unsubscribe write back; query leaves the row alone
          mem_we                 = evt_ok && obj_ok && (item.action != ACT_QUERY);
          out_load               = 1'b1;
          out_next.is_subscribed = evt_ok && obj_ok && hit;
          state_next             = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          out_load               = 1'b1;
          scan_load              = 1'b1;
          scan_next              = rest;
          out_next.result_kind   = KIND_DELIVERY;
          out_next.dest_object   = low_idx;
          out_next.add_reference = item.counted_event;
          out_next.last          = (rest == '0);
          if (rest == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // request latch and scan register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (scan_load) begin
      scan <= scan_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

// ===== src/esf_bit_unit.sv =====
// ----------------------------------------------------------------------------
// esf_bit_unit: shared row unit
// Sets, clears or tests one subscriber bit, and peels the lowest set bit off
// a row for the publish scan.
// ----------------------------------------------------------------------------
module esf_bit_unit
  import esf_pkg::*;
#(
  parameter int ROW_W = 32
) (
  input  logic [ROW_W-1:0] row,
  input  logic [OBJ_W-1:0] obj,
  input  action_t          action,
  output logic [ROW_W-1:0] upd_row,
  output logic             hit,
  output logic [OBJ_W-1:0] low_idx,
  output logic [ROW_W-1:0] rest
);

  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] lowbit;

  assign mask = ROW_W'(1) << obj;

  always_comb begin
    unique case (action)
      ACT_SUBSCRIBE:   upd_row = row | mask;
      ACT_UNSUBSCRIBE: upd_row = row & ~mask;
      default:         upd_row = row;
    endcase
  end

  assign hit = |(upd_row & mask);

  // two's complement trick isolates the lowest set bit
  assign lowbit = row & (~row + ROW_W'(1));
  assign rest   = row ^ lowbit;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (lowbit[i]) begin
        low_idx = low_idx | OBJ_W'(i);
      end
    end
  end

endmodule

// ===== test/tb_event_subscription_fanout.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_subscription_fanout: self-checking bench for the subscription bitmap
// Drives subscribe, unsubscribe, query and publish words with random gaps on
// both channels. A scoreboard keeps its own copy of the bitmap and checks every
// result word, field by field and in order. It also checks that the fan-out,
// release and silent cases match that copy.
// ----------------------------------------------------------------------------
module tb_event_subscription_fanout;
  import esf_pkg::*;

  localparam int NUM_OBJECTS = 32;
  localparam int NUM_EVENTS  = 64;
  localparam int LONG_HOLD   = 300;  // receiver hold-off, cycles

  // --------------------------------------------------------------------------
  // Scoreboard: subscriber bitmap shadow plus the queue of expected words.
  // --------------------------------------------------------------------------
  class fanout_scoreboard;
    logic [NUM_OBJECTS-1:0] subscribers [NUM_EVENTS];
    out_word_t              expected_q [$];
    int                     errors;

    function new();
      foreach (subscribers[i]) subscribers[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Work out every word that one accepted request will cause.
    function void note_request(in_word_t req);
      out_word_t              word;
      logic [NUM_OBJECTS-1:0] row;
      int                     total;
      int                     seen;
      word                = '0;
      word.event_out      = req.event_index;
      word.interrupt_path = req.from_interrupt;
      if (req.action == ACT_PUBLISH) begin
        row   = subscribers[req.event_index];
        total = $countones(row);
        seen  = 0;
        if (total == 0) begin
          // counted event nobody wants: release it; uncounted: silent
          if (req.counted_event) begin
            word.result_kind = KIND_RELEASE;
            word.last        = 1'b1;
            expected_q.push_back(word);
          end
        end else begin
          for (int i = 0; i < NUM_OBJECTS; i++) begin
            if (row[i]) begin
              seen               = seen + 1;
              word.result_kind   = KIND_DELIVERY;
              word.dest_object   = OBJ_W'(i);
              word.add_reference = req.counted_event;
              word.last          = (seen == total);
              expected_q.push_back(word);
            end
          end
        end
      end else begin
        if (req.action == ACT_SUBSCRIBE)
          subscribers[req.event_index][req.object_index] = 1'b1;
        else if (req.action == ACT_UNSUBSCRIBE)
          subscribers[req.event_index][req.object_index] = 1'b0;
        word.result_kind   = KIND_ACK;
        word.is_subscribed = subscribers[req.event_index][req.object_index];
        word.last          = 1'b1;
        expected_q.push_back(word);
      end
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors = errors + 1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("result_kind", 8'(want.result_kind), 8'(got.result_kind));
      compare("dest_object", 8'(want.dest_object), 8'(got.dest_object));
      compare("event_out", 8'(want.event_out), 8'(got.event_out));
      compare("add_reference", 8'(want.add_reference), 8'(got.add_reference));
      compare("is_subscribed", 8'(want.is_subscribed), 8'(got.is_subscribed));
      compare("interrupt_path", 8'(want.interrupt_path), 8'(got.interrupt_path));
      compare("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // idle-mode knobs shared by the sender, the receiver and the main sequence
  bit tx_steady    = 1'b0;  // sender offers back to back
  bit rx_steady    = 1'b0;  // receiver always ready
  bit hold_pending = 1'b0;  // receiver takes one long hold-off at next word

  fanout_scoreboard board = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  event_subscription_fanout #(
    .NUM_OBJECTS(NUM_OBJECTS),
    .NUM_EVENTS (NUM_EVENTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic in_word_t request(action_t act, int evt, int obj, bit counted, bit irq);
    in_word_t req;
    req.action         = act;
    req.event_index    = EVT_W'(evt);
    req.object_index   = OBJ_W'(obj);
    req.counted_event  = counted;
    req.from_interrupt = irq;
    return req;
  endfunction

  // Mix weighted toward building up rows on a few hot events so that
  // publishes actually fan out; the rest lands anywhere in the table.
  function automatic in_word_t random_request();
    int      pick;
    int      evt;
    action_t act;
    pick = $urandom_range(0, 99);
    if (pick < 40)      act = ACT_SUBSCRIBE;
    else if (pick < 55) act = ACT_UNSUBSCRIBE;
    else if (pick < 85) act = ACT_PUBLISH;
    else                act = ACT_QUERY;
    if ($urandom_range(0, 3) != 0)
      evt = 21 * $urandom_range(0, 3);  // hot rows 0, 21, 42, 63
    else
      evt = $urandom_range(0, NUM_EVENTS - 1);
    return request(act, evt, $urandom_range(0, NUM_OBJECTS - 1),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Called at a rising edge right after the previous word went in (or at
  // start). in_valid is only lowered when a gap follows, so a back-to-back
  // word never sees a low/high pair in the same step.
  task automatic push_request(input in_word_t req);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(req);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall per word, plus one long hold-off on request
  // so the block backs up and drops in_ready while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 14);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, fan-out of two, re-subscribe, unsubscribe of an
    // absent bit, release of a counted event, silent uncounted publish
    push_request(request(ACT_QUERY,       0,  0, 1'b0, 1'b0));
    push_request(request(ACT_PUBLISH,     0,  0, 1'b0, 1'b0));  // no word
    push_request(request(ACT_PUBLISH,     0,  0, 1'b1, 1'b1));  // release
    push_request(request(ACT_SUBSCRIBE,   63, 31, 1'b0, 1'b1));
    push_request(request(ACT_SUBSCRIBE,   63, 0,  1'b1, 1'b0));
    push_request(request(ACT_SUBSCRIBE,   63, 31, 1'b0, 1'b0));  // already set
    push_request(request(ACT_QUERY,       63, 31, 1'b1, 1'b1));
    push_request(request(ACT_PUBLISH,     63, 5,  1'b1, 1'b0));
    push_request(request(ACT_PUBLISH,     63, 0,  1'b0, 1'b1));
    push_request(request(ACT_UNSUBSCRIBE, 63, 31, 1'b0, 1'b0));
    push_request(request(ACT_QUERY,       63, 31, 1'b0, 1'b0));
    push_request(request(ACT_UNSUBSCRIBE, 63, 31, 1'b1, 1'b1));  // not set
    push_request(request(ACT_PUBLISH,     63, 31, 1'b1, 1'b1));  // only obj 0
    push_request(request(ACT_UNSUBSCRIBE, 63, 0,  1'b0, 1'b0));
    push_request(request(ACT_PUBLISH,     63, 0,  1'b1, 1'b0));  // release
    push_request(request(ACT_PUBLISH,     63, 0,  1'b0, 1'b0));  // no word
    push_request(request(ACT_SUBSCRIBE,   0,  16, 1'b0, 1'b1));
    push_request(request(ACT_QUERY,       0,  15, 1'b0, 1'b0));
    push_request(request(ACT_PUBLISH,     0,  21, 1'b0, 1'b1));

    // random phases with varied idling; phase 3 fills a whole row behind a
    // long receiver hold-off, then fans it out 32 wide
    for (int phase = 0; phase < 6; phase++) begin
      tx_steady = (phase == 1) || (phase == 4);
      rx_steady = (phase == 2) || (phase == 4);
      if (phase == 3) begin
        hold_pending = 1'b1;
        for (int obj = 0; obj < NUM_OBJECTS; obj++)
          push_request(request(ACT_SUBSCRIBE, 17, obj, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1))));
        push_request(request(ACT_PUBLISH, 17, 0, 1'b1, 1'($urandom_range(0, 1))));
      end
      for (int n = 0; n < 26; n++)
        push_request(random_request());
    end
    in_valid <= 1'b0;

    // drain, then allow for a last silent publish still in flight
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
